FILE: hdl/arx_pkg.sv
// arx_pkg: types, codes and round functions for the arx permutation round unit
`timescale 1ns / 1ps
package arx_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned OPCODE_W        = 3;
  localparam int unsigned ROUND_CFG_W     = 5;
  localparam int unsigned MAX_ROUNDS_DEF  = 16;
  localparam logic [ROUND_CFG_W-1:0] ROUND_CFG_RESET = 5'd8;

  localparam logic [OPCODE_W-1:0] OP_FWD_ROUNDS = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INV_ROUNDS = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_FWD_HALF_A = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_FWD_HALF_B = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_INV_HALF_B = 3'd4;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [3:0][WORD_W-1:0] state_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    word_t               word_in0;
    word_t               word_in1;
    word_t               word_in2;
    word_t               word_in3;
  } in_item_t;

  typedef struct packed {
    word_t word_out0;
    word_t word_out1;
    word_t word_out2;
    word_t word_out3;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } fsm_t;

  function automatic state_t half_a(input state_t w);
    state_t v;
    v = w;
    v[0] = v[0] + v[1];
    v[1] = ((v[1] << 5) | (v[1] >> 27)) ^ v[0];
    v[0] = (v[0] << 16) | (v[0] >> 16);
    v[2] = v[2] + v[3];
    v[3] = ((v[3] << 8) | (v[3] >> 24)) ^ v[2];
    return v;
  endfunction

  function automatic state_t half_b(input state_t w);
    state_t v;
    v = w;
    v[0] = v[0] + v[3];
    v[3] = ((v[3] << 13) | (v[3] >> 19)) ^ v[0];
    v[2] = v[2] + v[1];
    v[1] = ((v[1] << 7) | (v[1] >> 25)) ^ v[2];
    v[2] = (v[2] << 16) | (v[2] >> 16);
    return v;
  endfunction

  function automatic state_t inv_half_b(input state_t w);
    state_t v;
    word_t  t;
    v = w;
    v[2] = (v[2] >> 16) | (v[2] << 16);
    t = v[1] ^ v[2];
    v[1] = (t >> 7) | (t << 25);
    v[2] = v[2] - v[1];
    t = v[3] ^ v[0];
    v[3] = (t >> 13) | (t << 19);
    v[0] = v[0] - v[3];
    return v;
  endfunction

  function automatic state_t inv_half_a(input state_t w);
    state_t v;
    word_t  t;
    v = w;
    t = v[3] ^ v[2];
    v[3] = (t >> 8) | (t << 24);
    v[2] = v[2] - v[3];
    v[0] = (v[0] >> 16) | (v[0] << 16);
    t = v[1] ^ v[0];
    v[1] = (t >> 5) | (t << 27);
    v[0] = v[0] - v[1];
    return v;
  endfunction

endpackage

FILE: hdl/arx_round.sv
// arx_round: shared round datapath, one full round or one half round per use
`timescale 1ns / 1ps
module arx_round
  import arx_pkg::*;
(
  input  logic [OPCODE_W-1:0] op,
  input  state_t              state_in,
  output state_t              state_out
);

  always_comb begin
    unique case (op)
      OP_FWD_ROUNDS: state_out = half_b(half_a(state_in));
      OP_INV_ROUNDS: state_out = inv_half_a(inv_half_b(state_in));
      OP_FWD_HALF_A: state_out = half_a(state_in);
      OP_FWD_HALF_B: state_out = half_b(state_in);
      OP_INV_HALF_B: state_out = inv_half_b(state_in);
      default:       state_out = state_in;
    endcase
  end

endmodule

FILE: hdl/arx_permutation_round_unit_top.sv
// arx_permutation_round_unit_top: sequenced chaskey permutation round unit
`timescale 1ns / 1ps
// An item is taken when start is high and busy is low. Opcodes 0 and 1 run one
// full round per cycle through a single shared round datapath, round_count
// times (saturated at MAX_ROUNDS). After the last round the block enters the
// result state, which raises the out_valid strobe, and the next item can be
// taken in the cycle after the strobe. Half-round opcodes run one half round;
// unused opcodes and a zero round count go straight to the result state. busy
// stays high until the result cycle ends. The result is shown for one cycle
// with out_valid and cannot be held off by the receiver.
module arx_permutation_round_unit_top
  import arx_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = MAX_ROUNDS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  in_item_t               in_item,
  output logic                   out_valid,
  output out_item_t              out_item,
  input  logic                   cfg_we,
  input  logic [ROUND_CFG_W-1:0] cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(MAX_ROUNDS + 1);

  fsm_t                   state_r, state_nxt;
  logic [ROUND_CFG_W-1:0] round_cfg_r;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [OPCODE_W-1:0]    op_r, op_nxt;
  state_t                 words_r, words_nxt;
  state_t                 round_out;
  logic [CNT_W-1:0]       rounds_sat;
  logic                   accept;

  arx_round u_round (
    .op        (op_r),
    .state_in  (words_r),
    .state_out (round_out)
  );

  assign accept = start && !busy;

  always_comb begin
    if (int'(round_cfg_r) > int'(MAX_ROUNDS)) begin
      rounds_sat = CNT_W'(MAX_ROUNDS);
    end else begin
      rounds_sat = CNT_W'(round_cfg_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_cfg_r <= ROUND_CFG_RESET;
    end else if (cfg_we) begin
      round_cfg_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    words_r <= words_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    words_nxt = words_r;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          op_nxt    = in_item.opcode;
          words_nxt = {in_item.word_in3, in_item.word_in2,
                       in_item.word_in1, in_item.word_in0};
          priority if (in_item.opcode == OP_FWD_ROUNDS ||
                       in_item.opcode == OP_INV_ROUNDS) begin
            cnt_nxt = rounds_sat;
          end else if (in_item.opcode == OP_FWD_HALF_A ||
                       in_item.opcode == OP_FWD_HALF_B ||
                       in_item.opcode == OP_INV_HALF_B) begin
            cnt_nxt = CNT_W'(1);
          end else begin
            cnt_nxt = '0;
          end
          state_nxt = (cnt_nxt != '0) ? ST_RUN : ST_EMIT;
        end
      end
      ST_RUN: begin
        words_nxt = round_out;
        cnt_nxt   = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_item = '{word_out0: words_r[0], word_out1: words_r[1],
                      word_out2: words_r[2], word_out3: words_r[3]};

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("accepted item did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy) else $error("result strobe not single");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result shown while idle");

  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> cnt_r != '0) else $error("round count empty in run");

endmodule
